### hdl/nis_pkg.sv
// Package for the Newton integer square root unit.
// Holds field widths, the controller state type and the divider status struct.
// No dependencies.
`timescale 1ns / 1ps

package nis_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned ROOT_WIDTH    = 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_UPDATE,
    S_DONE
  } nis_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } nis_div_status_t;

endpackage

### hdl/nis_operand_if.sv
// Request channel of the square root unit: valid/ready plus the operand.
// Depends on nis_pkg.
`timescale 1ns / 1ps

interface nis_operand_if
  import nis_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

### hdl/nis_root_if.sv
// Result channel of the square root unit: valid/ready plus the root.
// Depends on nis_pkg.
`timescale 1ns / 1ps

interface nis_root_if
  import nis_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ROOT_WIDTH-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

### hdl/newton_integer_sqrt16_unit.sv
// Integer square root by Newton rounds, one request at a time.
// A zero operand goes straight to the done state; otherwise each round starts the
// serial divider (one quotient bit per cycle), averages the guess with the quotient
// and stops once the guess drops by no more than one or the round count reaches
// 2 * DATA_WIDTH + 8. The next request is taken only after the result is loaded
// into the output register, so requests do not overlap.
// Reset clears the controller and the output valid flag.
// Depends on nis_pkg, nis_operand_if, nis_root_if and nis_div.
`timescale 1ns / 1ps

module newton_integer_sqrt16_unit
  import nis_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nis_operand_if.sink   operand_i,
  nis_root_if.source    root_o
);

  localparam int unsigned MAX_ROUNDS = 2 * DATA_WIDTH + 8;
  localparam int unsigned RND_W      = $clog2(MAX_ROUNDS + 1);

  nis_state_e            state_q, state_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic [DATA_WIDTH-1:0] guess_q, guess_d;
  logic [RND_W-1:0]      rounds_q, rounds_d;
  logic                  out_valid_q, out_valid_d;
  logic [ROOT_WIDTH-1:0] root_q, root_d;

  logic                  in_ready;
  logic                  accept;
  logic                  div_start;
  logic                  out_load;
  logic                  finished;
  logic [DATA_WIDTH-1:0] in_value;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH-1:0] guess_new;
  logic [DATA_WIDTH-1:0] change;
  logic [RND_W-1:0]      rounds_next;
  nis_div_status_t       div_st;

  nis_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (value_q),
    .divisor_i  (guess_q),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  assign in_value    = DATA_WIDTH'(operand_i.operand);
  assign accept      = operand_i.valid && in_ready;
  assign sum         = {1'b0, guess_q} + {1'b0, quotient};
  assign guess_new   = sum[DATA_WIDTH:1];
  // The change wraps, so a rising guess keeps the iteration going.
  assign change      = guess_q - guess_new;
  assign rounds_next = rounds_q + 1'b1;
  assign finished    = (change[DATA_WIDTH-1:1] == '0) ||
                       (rounds_next >= RND_W'(MAX_ROUNDS));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (operand_i.valid) begin
          state_d = (in_value == '0) ? S_DONE : S_START;
        end
      end
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: state_d = finished ? S_DONE : S_START;
      S_DONE: begin
        if (!out_valid_q || root_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready  = 1'b1;
      S_START:  div_start = 1'b1;
      S_DIV:    ;
      S_UPDATE: ;
      S_DONE:   out_load  = !out_valid_q || root_o.ready;
      default:  ;
    endcase
  end

  // Datapath.
  always_comb begin
    value_d     = value_q;
    guess_d     = guess_q;
    rounds_d    = rounds_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      value_d  = in_value;
      guess_d  = in_value;
      rounds_d = '0;
    end else if (state_q == S_UPDATE) begin
      guess_d  = guess_new;
      rounds_d = rounds_next;
    end
    if (out_load) begin
      root_d      = ROOT_WIDTH'(guess_q);
      out_valid_d = 1'b1;
    end else if (root_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rounds_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rounds_q    <= rounds_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    guess_q <= guess_d;
    root_q  <= root_d;
  end

  assign operand_i.ready = in_ready;
  assign root_o.valid    = out_valid_q;
  assign root_o.root     = root_q;

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> guess_q != '0)
    else $error("division started with a zero guess");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside the done phase");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rounds_q <= RND_W'(MAX_ROUNDS))
    else $error("round count beyond its bound");

endmodule

### hdl/nis_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nis_pkg for the status struct.
`timescale 1ns / 1ps

module nis_div
  import nis_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output nis_div_status_t       status_o,
  output logic [DATA_WIDTH-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] shreg_q, shreg_d;
  logic [DATA_WIDTH-1:0] divisor_q, divisor_d;
  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH:0]   rem_diff;
  logic                  fits;

  // Bring the next dividend bit into the partial remainder and try the subtract.
  assign rem_shift = {rem_q, shreg_q[DATA_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_q};
  assign fits      = ~rem_diff[DATA_WIDTH];

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    shreg_d   = shreg_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = CNT_W'(DATA_WIDTH - 1);
      rem_d     = '0;
      shreg_d   = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      rem_d   = fits ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
      shreg_d = {shreg_q[DATA_WIDTH-2:0], fits};
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    shreg_q   <= shreg_d;
    divisor_q <= divisor_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = shreg_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && divisor_q != '0) |-> rem_q < divisor_q)
    else $error("final remainder not below divisor");

endmodule

### bench/tb_newton_integer_sqrt16_unit.sv
// Testbench for newton_integer_sqrt16_unit: directed corner operands, a long result
// back-pressure stretch and random operands, all checked against a local root predictor.
// Depends on nis_pkg, nis_operand_if, nis_root_if and the unit itself.
`timescale 1ns / 1ps

module tb_newton_integer_sqrt16_unit;
  import nis_pkg::*;

  localparam int unsigned CLK_HALF_NS  = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned MAX_ROUNDS   = 2 * OPERAND_WIDTH + 8;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned STALL_CYCLES = 1200;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned TIMEOUT_NS = 64'd60_000_000;

  localparam logic [OPERAND_WIDTH-1:0] CORNER_OPERANDS [24] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd15, 16'd16,
    16'd99, 16'd100, 16'd255, 16'd256, 16'd4095, 16'd4096, 16'd16383, 16'd16384,
    16'd32768, 16'd65024, 16'd65025, 16'd65026, 16'd65534, 16'd65535,
    16'h5555, 16'hAAAA
  };

  logic clk_i;
  logic rst_ni;

  nis_operand_if operand_bus ();
  nis_root_if    root_bus ();

  newton_integer_sqrt16_unit #(
    .DATA_WIDTH(OPERAND_WIDTH)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .operand_i(operand_bus),
    .root_o   (root_bus)
  );

  logic [ROOT_WIDTH-1:0] expected_roots [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  int unsigned requests_sent;
  int unsigned roots_checked;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
  end

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // Heron rounds at the operand width; the change wraps, so a rising guess keeps going.
  function automatic logic [ROOT_WIDTH-1:0] predict_root(input logic [OPERAND_WIDTH-1:0] value);
    logic [OPERAND_WIDTH:0]   sum;
    logic [OPERAND_WIDTH-1:0] guess;
    logic [OPERAND_WIDTH-1:0] prior;
    logic [OPERAND_WIDTH-1:0] delta;
    int unsigned              rounds;
    if (value == '0) begin
      return '0;
    end
    guess  = value;
    rounds = 0;
    do begin
      prior = guess;
      if (guess == '0) begin
        break;
      end
      sum    = {1'b0, guess} + {1'b0, value / guess};
      guess  = sum[OPERAND_WIDTH:1];
      delta  = prior - guess;
      rounds++;
    end while (delta > 1 && rounds < MAX_ROUNDS);
    return guess[ROOT_WIDTH-1:0];
  endfunction

  // Offers one request, with random idle cycles first, and logs its expected root.
  task automatic send_operand(input logic [OPERAND_WIDTH-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      operand_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    operand_bus.valid   = 1'b1;
    operand_bus.operand = value;
    @(posedge clk_i);
    while (!operand_bus.ready) begin
      @(posedge clk_i);
    end
    expected_roots.push_back(predict_root(value));
    requests_sent++;
  endtask

  task automatic test_corner_operands();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (CORNER_OPERANDS[i]) begin
      send_operand(CORNER_OPERANDS[i]);
    end
  endtask

  // The result side stalls for a long stretch, so the unit holds a finished root
  // and must refuse the requests still being offered.
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    stall_left = STALL_CYCLES;
    repeat (6) begin
      send_operand(16'($urandom_range(65535)));
    end
    while (stall_left != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic test_random_operands(input int unsigned count, input int unsigned send_pct,
                                      input int unsigned recv_pct);
    int unsigned              pick;
    int unsigned              base;
    logic [OPERAND_WIDTH-1:0] value;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        value = 16'($urandom_range(65535));
      end else if (pick < 70) begin
        // Near a perfect square, where the guess tends to settle one above the root.
        base  = $urandom_range(255, 1);
        value = 16'(base * base + $urandom_range(2) - 1);
      end else if (pick < 90) begin
        value = 16'($urandom_range(1023));
      end else begin
        value = {1'b1, 15'($urandom_range(32767))};
      end
      send_operand(value);
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left      = stall_left - 1;
      root_bus.ready  = 1'b0;
    end else begin
      root_bus.ready  = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && root_bus.valid && root_bus.ready) begin
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected root %0d with no request outstanding", root_bus.root);
        end
      end else begin
        if (root_bus.root !== expected_roots[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("root mismatch: expected %0d, got %0d", expected_roots[0], root_bus.root);
          end
        end
        void'(expected_roots.pop_front());
        roots_checked++;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    operand_bus.valid   = 1'b0;
    operand_bus.operand = '0;
    root_bus.ready      = 1'b0;
    rst_ni              = 1'b0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    stall_left          = 0;
    requests_sent       = 0;
    roots_checked       = 0;
    mismatches          = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_corner_operands();
    test_result_backpressure();
    test_random_operands(480, 36, 58);
    test_random_operands(480, 58, 36);
    test_random_operands(460, 0, 0);

    @(negedge clk_i);
    operand_bus.valid = 1'b0;
    while (expected_roots.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_roots.size() != 0) begin
      mismatches++;
    end
    $display("Sent %0d square root requests (corner operands, a long result stall,",
             requests_sent);
    $display("random operands under three idle mixes); %0d roots checked, %0d mismatches.",
             roots_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/nis_pkg.sv
hdl/nis_operand_if.sv
hdl/nis_root_if.sv
hdl/nis_div.sv
hdl/newton_integer_sqrt16_unit.sv
bench/tb_newton_integer_sqrt16_unit.sv
